@@ sv/capacity_table_with_waiting_queue_assert.svh @@
// Assertion macros for the capacity table. Each one samples on the rising edge
// of clk and is disabled while rst is high.
`ifndef CAPACITY_TABLE_WITH_WAITING_QUEUE_ASSERT_SVH
`define CAPACITY_TABLE_WITH_WAITING_QUEUE_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define CTWQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("capacity table check failed");
`define CTWQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("capacity table check failed");
`else
`define CTWQ_ASSERT_IMP(lbl, ante, cons)
`define CTWQ_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ sv/ctwq_pkg.sv @@
package ctwq_pkg;

  localparam int MAIN_DEPTH  = 128;
  localparam int QUEUE_DEPTH = 64;
  localparam int IDENT_W     = 32;
  localparam int CAP_CFG_W   = 8;
  localparam int CAP_RESET   = 100;

  // Widths of the result fields.
  localparam int POS_W = 7;
  localparam int MC_W  = 8;
  localparam int QC_W  = 7;

  localparam int MI_W  = (MAIN_DEPTH > 1) ? $clog2(MAIN_DEPTH) : 1;
  localparam int QI_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int MF_W  = $clog2(MAIN_DEPTH + 1);
  localparam int QF_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int CAP_W = (MF_W > CAP_CFG_W) ? MF_W : CAP_CFG_W;

  // The match scanner is shared in shape by both tables and sized for the larger.
  localparam int SCAN_DEPTH = (MAIN_DEPTH > QUEUE_DEPTH) ? MAIN_DEPTH : QUEUE_DEPTH;
  localparam int GRP        = 8;
  localparam int GRP_W      = 3;
  localparam int NGRP       = (SCAN_DEPTH + GRP - 1) / GRP;
  localparam int NGRP_W     = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int SIDX_W     = NGRP_W + GRP_W;

  typedef enum logic [1:0] {
    KIND_REGISTER = 2'd0,
    KIND_SEARCH   = 2'd1,
    KIND_DELETE   = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    STAT_ADD_MAIN    = 3'd0,
    STAT_ADD_QUEUE   = 3'd1,
    STAT_QUEUE_FULL  = 3'd2,
    STAT_FOUND_MAIN  = 3'd3,
    STAT_FOUND_QUEUE = 3'd4,
    STAT_NOT_FOUND   = 3'd5,
    STAT_DELETED     = 3'd6,
    STAT_DELETE_MISS = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_SCAN,
    S_RES
  } state_t;

endpackage

@@ sv/ctwq_cell.sv @@
// One table slot: holds an identifier, takes a new one or its right
// neighbor's, and registers whether it matches the broadcast key.
module ctwq_cell (
  input  logic                        clk,
  input  logic                        load,
  input  logic                        shift,
  input  logic [ctwq_pkg::IDENT_W-1:0] load_data,
  input  logic [ctwq_pkg::IDENT_W-1:0] next_data,
  input  logic [ctwq_pkg::IDENT_W-1:0] key,
  output logic [ctwq_pkg::IDENT_W-1:0] data,
  output logic                        hit
);

  always_ff @(posedge clk) begin
    if (load) begin
      data <= load_data;
    end else if (shift) begin
      data <= next_data;
    end
    hit <= (data == key);
  end

endmodule

@@ sv/ctwq_scan.sv @@
// Two-level first-match finder: groups of eight are encoded into a register,
// then the lowest group with a hit selects the final index.
module ctwq_scan (
  input  logic                          clk,
  input  logic [ctwq_pkg::SCAN_DEPTH-1:0] hits,
  output logic                          found,
  output logic [ctwq_pkg::SIDX_W-1:0]     idx
);

  logic [ctwq_pkg::NGRP*ctwq_pkg::GRP-1:0] padded;
  logic [ctwq_pkg::NGRP-1:0]               grp_any;
  logic [ctwq_pkg::GRP_W-1:0]              grp_loc [ctwq_pkg::NGRP];
  logic [ctwq_pkg::NGRP-1:0]               any_next;
  logic [ctwq_pkg::GRP_W-1:0]              loc_next [ctwq_pkg::NGRP];

  always_comb begin
    padded = '0;
    padded[ctwq_pkg::SCAN_DEPTH-1:0] = hits;
    for (int g = 0; g < ctwq_pkg::NGRP; g++) begin
      any_next[g] = 1'b0;
      loc_next[g] = '0;
      for (int b = ctwq_pkg::GRP - 1; b >= 0; b--) begin
        if (padded[g*ctwq_pkg::GRP + b]) begin
          any_next[g] = 1'b1;
          loc_next[g] = ctwq_pkg::GRP_W'(b);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    grp_any <= any_next;
    grp_loc <= loc_next;
  end

  always_comb begin
    found = 1'b0;
    idx   = '0;
    for (int g = ctwq_pkg::NGRP - 1; g >= 0; g--) begin
      if (grp_any[g]) begin
        found = 1'b1;
        idx   = {ctwq_pkg::NGRP_W'(g), grp_loc[g]};
      end
    end
  end

endmodule

@@ sv/capacity_table_with_waiting_queue.sv @@
// The key is registered on accept, then the cell match flags, the group scan and the result in turn.
// A new beat is taken only in the idle state, once the compare, group-scan and update steps of the
// cell rows are done; it is taken while the previous result still waits on the output.
// Reset (synchronous, active high): both tables empty, capacity 100, no result pending.
// Table contents are not cleared; slots beyond the fill counts are never read.
`include "capacity_table_with_waiting_queue_assert.svh"

module capacity_table_with_waiting_queue (
  input  logic                            clk,
  input  logic                            rst,
  // Configuration: capacity of the main table.
  input  logic                            cfg_wen,
  input  logic [ctwq_pkg::CAP_CFG_W-1:0]  cfg_wdata,
  // Request stream.
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [31:0]                     s_tdata,   // [31:0] ident
  input  logic [1:0]                      s_tuser,   // [1:0] kind
  // Result stream.
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [6:0] position, [14:7] main_count, [21:15] queue_count, [22] promoted,
  // [54:23] promoted_ident, [55] zero
  output logic [55:0]                     m_tdata,
  output logic [2:0]                      m_tuser    // [2:0] status
);

  // The main table and the overflow queue are each a row of identical cells.
  // Slot 0 of the main row is the oldest entry and new entries go in at the
  // fill count; a delete shifts every slot at or above the hit one step down.
  // The queue row is kept in age order the same way, so its head is always
  // slot 0 and a promotion shifts the whole row down by one.

  ctwq_pkg::state_t state, state_next;

  logic [ctwq_pkg::CAP_CFG_W-1:0] cap_cfg;
  logic [ctwq_pkg::MF_W-1:0]      main_fill, main_fill_next;
  logic [ctwq_pkg::QF_W-1:0]      queue_fill, queue_fill_next;
  ctwq_pkg::kind_t                kind;
  logic [ctwq_pkg::IDENT_W-1:0]   key;

  logic accept;
  logic res_ok;

  // Cell rows.
  logic [ctwq_pkg::IDENT_W-1:0] m_data [ctwq_pkg::MAIN_DEPTH];
  logic [ctwq_pkg::IDENT_W-1:0] q_data [ctwq_pkg::QUEUE_DEPTH];
  logic [ctwq_pkg::MAIN_DEPTH-1:0]  m_hit;
  logic [ctwq_pkg::QUEUE_DEPTH-1:0] q_hit;
  logic [ctwq_pkg::SCAN_DEPTH-1:0]  m_scan_in, q_scan_in;
  logic                             m_found, q_found;
  logic [ctwq_pkg::SIDX_W-1:0]      m_sidx, q_sidx;
  logic [ctwq_pkg::MI_W-1:0]        m_idx;
  logic [ctwq_pkg::QI_W-1:0]        q_idx;

  // Update controls, decided in the result step.
  logic                         m_load, m_shift, q_load, q_shift;
  logic [ctwq_pkg::MI_W-1:0]    m_load_idx;
  logic [ctwq_pkg::QI_W-1:0]    q_load_idx;
  logic [ctwq_pkg::IDENT_W-1:0] m_load_data;
  logic [ctwq_pkg::CAP_W-1:0]   cap;
  logic [ctwq_pkg::MF_W-1:0]    fill_after;
  logic                         prom;
  logic [ctwq_pkg::IDENT_W-1:0] prom_id;
  ctwq_pkg::status_t            status;
  logic [ctwq_pkg::POS_W-1:0]   pos;

  // Result register.
  ctwq_pkg::status_t            r_status;
  logic [ctwq_pkg::POS_W-1:0]   r_pos;
  logic [ctwq_pkg::MC_W-1:0]    r_mc;
  logic [ctwq_pkg::QC_W-1:0]    r_qc;
  logic                         r_prom;
  logic [ctwq_pkg::IDENT_W-1:0] r_prom_id;
  logic                         r_is_delete;

  // Sequencer: accept, compare in every cell, group scan, then result and update.
  always_comb begin
    state_next = state;
    unique case (state)
      ctwq_pkg::S_IDLE: begin
        if (s_tvalid) begin
          state_next = ctwq_pkg::S_CMP;
        end
      end
      ctwq_pkg::S_CMP:  state_next = ctwq_pkg::S_SCAN;
      ctwq_pkg::S_SCAN: state_next = ctwq_pkg::S_RES;
      ctwq_pkg::S_RES: begin
        if (!m_tvalid || m_tready) begin
          state_next = ctwq_pkg::S_IDLE;
        end
      end
      default: state_next = ctwq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    s_tready = (state == ctwq_pkg::S_IDLE);
    accept   = s_tvalid && s_tready;
    res_ok   = (state == ctwq_pkg::S_RES) && (!m_tvalid || m_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ctwq_pkg::S_IDLE;
      cap_cfg    <= ctwq_pkg::CAP_CFG_W'(ctwq_pkg::CAP_RESET);
      main_fill  <= '0;
      queue_fill <= '0;
    end else begin
      state <= state_next;
      if (cfg_wen) begin
        cap_cfg <= cfg_wdata;
      end
      if (res_ok) begin
        main_fill  <= main_fill_next;
        queue_fill <= queue_fill_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind <= ctwq_pkg::kind_t'(s_tuser);
      key  <= s_tdata;
    end
  end

  // Main table row.
  for (genvar i = 0; i < ctwq_pkg::MAIN_DEPTH; i++) begin : g_main
    logic ld, sh;
    assign ld = m_load && (m_load_idx == ctwq_pkg::MI_W'(i));
    assign sh = m_shift && (ctwq_pkg::MI_W'(i) >= m_idx);
    ctwq_cell u_cell (
      .clk       (clk),
      .load      (ld),
      .shift     (sh),
      .load_data (m_load_data),
      .next_data (m_data[(i + 1 < ctwq_pkg::MAIN_DEPTH) ? i + 1 : i]),
      .key       (key),
      .data      (m_data[i]),
      .hit       (m_hit[i])
    );
  end

  // Overflow queue row, oldest entry in slot 0.
  for (genvar i = 0; i < ctwq_pkg::QUEUE_DEPTH; i++) begin : g_queue
    logic ld;
    assign ld = q_load && (q_load_idx == ctwq_pkg::QI_W'(i));
    ctwq_cell u_cell (
      .clk       (clk),
      .load      (ld),
      .shift     (q_shift),
      .load_data (key),
      .next_data (q_data[(i + 1 < ctwq_pkg::QUEUE_DEPTH) ? i + 1 : i]),
      .key       (key),
      .data      (q_data[i]),
      .hit       (q_hit[i])
    );
  end

  // Only slots below the fill count take part in a search.
  always_comb begin
    m_scan_in = '0;
    q_scan_in = '0;
    for (int i = 0; i < ctwq_pkg::MAIN_DEPTH; i++) begin
      m_scan_in[i] = m_hit[i] && (ctwq_pkg::MF_W'(i) < main_fill);
    end
    for (int i = 0; i < ctwq_pkg::QUEUE_DEPTH; i++) begin
      q_scan_in[i] = q_hit[i] && (ctwq_pkg::QF_W'(i) < queue_fill);
    end
  end

  ctwq_scan u_main_scan (
    .clk   (clk),
    .hits  (m_scan_in),
    .found (m_found),
    .idx   (m_sidx)
  );

  ctwq_scan u_queue_scan (
    .clk   (clk),
    .hits  (q_scan_in),
    .found (q_found),
    .idx   (q_sidx)
  );

  assign m_idx = m_sidx[ctwq_pkg::MI_W-1:0];
  assign q_idx = q_sidx[ctwq_pkg::QI_W-1:0];

  // Result and update decision. A capacity above the table depth is limited
  // to the depth, so a fill below the capacity always leaves a free slot.
  always_comb begin
    if (ctwq_pkg::CAP_W'(cap_cfg) > ctwq_pkg::CAP_W'(ctwq_pkg::MAIN_DEPTH)) begin
      cap = ctwq_pkg::CAP_W'(ctwq_pkg::MAIN_DEPTH);
    end else begin
      cap = ctwq_pkg::CAP_W'(cap_cfg);
    end
    status          = ctwq_pkg::STAT_NOT_FOUND;
    pos             = '0;
    m_load          = 1'b0;
    m_shift         = 1'b0;
    q_load          = 1'b0;
    q_shift         = 1'b0;
    m_load_idx      = main_fill[ctwq_pkg::MI_W-1:0];
    q_load_idx      = queue_fill[ctwq_pkg::QI_W-1:0];
    m_load_data     = key;
    prom            = 1'b0;
    prom_id         = '0;
    fill_after      = main_fill;
    main_fill_next  = main_fill;
    queue_fill_next = queue_fill;
    case (kind)
      ctwq_pkg::KIND_REGISTER: begin
        if (ctwq_pkg::CAP_W'(main_fill) < cap) begin
          status         = ctwq_pkg::STAT_ADD_MAIN;
          pos            = ctwq_pkg::POS_W'(main_fill);
          m_load         = res_ok;
          main_fill_next = main_fill + 1'b1;
        end else if (queue_fill < ctwq_pkg::QF_W'(ctwq_pkg::QUEUE_DEPTH)) begin
          status          = ctwq_pkg::STAT_ADD_QUEUE;
          pos             = ctwq_pkg::POS_W'(queue_fill);
          q_load          = res_ok;
          queue_fill_next = queue_fill + 1'b1;
        end else begin
          status = ctwq_pkg::STAT_QUEUE_FULL;
        end
      end
      ctwq_pkg::KIND_SEARCH: begin
        if (m_found) begin
          status = ctwq_pkg::STAT_FOUND_MAIN;
          pos    = ctwq_pkg::POS_W'(m_idx);
        end else if (q_found) begin
          status = ctwq_pkg::STAT_FOUND_QUEUE;
          pos    = ctwq_pkg::POS_W'(q_idx);
        end
      end
      ctwq_pkg::KIND_DELETE: begin
        status = ctwq_pkg::STAT_DELETE_MISS;
        if (m_found) begin
          status     = ctwq_pkg::STAT_DELETED;
          pos        = ctwq_pkg::POS_W'(m_idx);
          m_shift    = res_ok;
          fill_after = main_fill - 1'b1;
        end
        main_fill_next = fill_after;
        // The queue head moves to the end of the compacted table; this load
        // wins over the shift in that slot.
        if ((ctwq_pkg::CAP_W'(fill_after) < cap) && (queue_fill != '0)) begin
          prom            = 1'b1;
          prom_id         = q_data[0];
          m_load          = res_ok;
          m_load_idx      = fill_after[ctwq_pkg::MI_W-1:0];
          m_load_data     = q_data[0];
          q_shift         = res_ok;
          main_fill_next  = fill_after + 1'b1;
          queue_fill_next = queue_fill - 1'b1;
        end
      end
      default: begin
        status = ctwq_pkg::STAT_NOT_FOUND;
      end
    endcase
  end

  // Output register: a finished result waits here while the next beat is
  // already being worked on.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ok) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ok) begin
      r_status  <= status;
      r_pos     <= pos;
      r_mc      <= ctwq_pkg::MC_W'(main_fill_next);
      r_qc      <= ctwq_pkg::QC_W'(queue_fill_next);
      r_prom    <= prom;
      r_prom_id <= prom_id;
    end
  end

  assign m_tdata = {1'b0, r_prom_id, r_prom, r_qc, r_mc, r_pos};
  assign m_tuser = r_status;

  // A promotion only ever comes with the result of a delete, hit or miss.
  assign r_is_delete = (r_status == ctwq_pkg::STAT_DELETED) ||
                       (r_status == ctwq_pkg::STAT_DELETE_MISS);

  `CTWQ_ASSERT_IMP(a_main_fill_bound, 1'b1, main_fill <= ctwq_pkg::MF_W'(ctwq_pkg::MAIN_DEPTH))
  `CTWQ_ASSERT_IMP(a_queue_fill_bound, 1'b1, queue_fill <= ctwq_pkg::QF_W'(ctwq_pkg::QUEUE_DEPTH))
  `CTWQ_ASSERT_NEXT(a_result_lands, res_ok, m_tvalid)
  `CTWQ_ASSERT_IMP(a_prom_on_delete, m_tvalid && r_prom, r_is_delete)

endmodule

@@ bench/capacity_table_with_waiting_queue_tb.sv @@
`timescale 1ns / 1ps

module capacity_table_with_waiting_queue_tb;

  // The package names only the three operations, so the spare code of the kind field
  // gets a name of its own here. The block must treat it as a search that never hits.
  localparam logic [1:0] KIND_RESERVED = 2'd3;

  // One request beat as the driver puts it on the slave side.
  typedef struct {
    logic [1:0]                   kind;
    logic [ctwq_pkg::IDENT_W-1:0] ident;
  } table_request_t;

  // One result beat, with the fields unpacked from m_tdata and m_tuser.
  typedef struct {
    ctwq_pkg::status_t            status;
    logic [ctwq_pkg::POS_W-1:0]   position;
    logic [ctwq_pkg::MC_W-1:0]    main_count;
    logic [ctwq_pkg::QC_W-1:0]    queue_count;
    logic                         promoted;
    logic [ctwq_pkg::IDENT_W-1:0] promoted_ident;
  } table_result_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_wen = 1'b0;
  logic [ctwq_pkg::CAP_CFG_W-1:0] cfg_wdata = '0;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [31:0]                    s_tdata = '0;   // [31:0] ident
  logic [1:0]                     s_tuser = '0;   // [1:0] kind
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  // [6:0] position, [14:7] main_count, [21:15] queue_count, [22] promoted,
  // [54:23] promoted_ident, [55] zero
  logic [55:0]                    m_tdata;
  logic [2:0]                     m_tuser;        // [2:0] status

  capacity_table_with_waiting_queue i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_wen  (cfg_wen),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Requests that still have to be put on the bus, and the results that the
  // shadow tables say must come back, oldest first.
  table_request_t pending_requests[$];
  table_result_t  awaited_results[$];
  int             mismatch_count = 0;
  // Chance in percent that either side holds off at a given clock edge.
  int             idle_pct = 37;

  // Shadow copy of the block state. The main table is kept packed from index zero,
  // and the waiting queue is a ring that starts at wait_head.
  logic [ctwq_pkg::IDENT_W-1:0] main_ids[ctwq_pkg::MAIN_DEPTH];
  int                           main_used = 0;
  logic [ctwq_pkg::IDENT_W-1:0] wait_ids[ctwq_pkg::QUEUE_DEPTH];
  int                           wait_head = 0;
  int                           wait_used = 0;
  int                           capacity_setting = ctwq_pkg::CAP_RESET;

  // Applies one request to the shadow tables and returns the result the block owes.
  function automatic table_result_t predict_table_op(
      input logic [1:0] kind, input logic [ctwq_pkg::IDENT_W-1:0] ident);
    table_result_t r;
    int            limit;
    int            hit;
    int            i;
    r.status         = ctwq_pkg::STAT_NOT_FOUND;
    r.position       = '0;
    r.promoted       = 1'b0;
    r.promoted_ident = '0;
    // A capacity above the table depth acts as the depth.
    limit = (capacity_setting > ctwq_pkg::MAIN_DEPTH) ? ctwq_pkg::MAIN_DEPTH
                                                      : capacity_setting;
    hit   = -1;
    case (kind)
      ctwq_pkg::KIND_REGISTER: begin
        if (main_used < limit) begin
          main_ids[main_used] = ident;
          r.position = ctwq_pkg::POS_W'(main_used);
          main_used++;
          r.status = ctwq_pkg::STAT_ADD_MAIN;
        end else if (wait_used < ctwq_pkg::QUEUE_DEPTH) begin
          wait_ids[(wait_head + wait_used) % ctwq_pkg::QUEUE_DEPTH] = ident;
          r.position = ctwq_pkg::POS_W'(wait_used);
          wait_used++;
          r.status = ctwq_pkg::STAT_ADD_QUEUE;
        end else begin
          r.status = ctwq_pkg::STAT_QUEUE_FULL;
        end
      end
      ctwq_pkg::KIND_SEARCH: begin
        for (i = 0; i < main_used && hit < 0; i++) begin
          if (main_ids[i] == ident) hit = i;
        end
        if (hit >= 0) begin
          r.status   = ctwq_pkg::STAT_FOUND_MAIN;
          r.position = ctwq_pkg::POS_W'(hit);
        end else begin
          for (i = 0; i < wait_used && hit < 0; i++) begin
            if (wait_ids[(wait_head + i) % ctwq_pkg::QUEUE_DEPTH] == ident) hit = i;
          end
          if (hit >= 0) begin
            r.status   = ctwq_pkg::STAT_FOUND_QUEUE;
            r.position = ctwq_pkg::POS_W'(hit);
          end
        end
      end
      ctwq_pkg::KIND_DELETE: begin
        r.status = ctwq_pkg::STAT_DELETE_MISS;
        for (i = 0; i < main_used && hit < 0; i++) begin
          if (main_ids[i] == ident) hit = i;
        end
        if (hit >= 0) begin
          for (i = hit; i < main_used - 1; i++) main_ids[i] = main_ids[i + 1];
          main_used--;
          r.position = ctwq_pkg::POS_W'(hit);
          r.status   = ctwq_pkg::STAT_DELETED;
        end
        // Promotion is checked on every delete, hit or miss.
        if (main_used < limit && wait_used > 0) begin
          r.promoted_ident = wait_ids[wait_head];
          wait_head = (wait_head + 1) % ctwq_pkg::QUEUE_DEPTH;
          wait_used--;
          main_ids[main_used] = r.promoted_ident;
          main_used++;
          r.promoted = 1'b1;
        end
      end
      default: ;
    endcase
    r.main_count  = ctwq_pkg::MC_W'(main_used);
    r.queue_count = ctwq_pkg::QC_W'(wait_used);
    return r;
  endfunction

  // Request driver. A beat is taken at an edge where tvalid and tready are both high;
  // at that same edge its result is predicted and the next beat, or a gap, is put up.
  always @(posedge clk) begin
    table_request_t next_req;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        awaited_results.push_back(predict_table_op(s_tuser, s_tdata));
      end
      if (!s_tvalid || s_tready) begin
        if (pending_requests.size() > 0 && $urandom_range(99) >= idle_pct) begin
          next_req = pending_requests.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= next_req.ident;
          s_tuser  <= next_req.kind;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor. Every beat taken on the master side is checked field by field
  // against the oldest prediction; m_tready is dropped at random to stall the block.
  always @(posedge clk) begin
    table_result_t want;
    table_result_t got;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.status         = ctwq_pkg::status_t'(m_tuser);
        got.position       = m_tdata[6:0];
        got.main_count     = m_tdata[14:7];
        got.queue_count    = m_tdata[21:15];
        got.promoted       = m_tdata[22];
        got.promoted_ident = m_tdata[54:23];
        if (awaited_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("unexpected result beat: status %0d position %0d", m_tuser, got.position);
          end
        end else begin
          want = awaited_results.pop_front();
          if (got.status !== want.status || got.position !== want.position ||
              got.main_count !== want.main_count || got.queue_count !== want.queue_count ||
              got.promoted !== want.promoted || got.promoted_ident !== want.promoted_ident) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("mismatch: expected status %0d pos %0d main %0d queue %0d prom %0b id %h",
                       want.status, want.position, want.main_count, want.queue_count,
                       want.promoted, want.promoted_ident);
              $display("          actual   status %0d pos %0d main %0d queue %0d prom %0b id %h",
                       m_tuser, got.position, got.main_count, got.queue_count,
                       got.promoted, got.promoted_ident);
            end
          end
        end
      end
      m_tready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // A pool of identifiers that requests mostly draw from, so that searches and
  // deletes hit entries and duplicates pile up. The rest are full random words.
  logic [ctwq_pkg::IDENT_W-1:0] ident_pool[16];

  task automatic queue_request(input logic [1:0] kind,
                               input logic [ctwq_pkg::IDENT_W-1:0] ident);
    table_request_t req;
    req.kind  = kind;
    req.ident = ident;
    pending_requests.push_back(req);
  endtask

  // Waits until every request has been taken and answered, then lets the clock run on
  // idle before it returns.
  task automatic wait_for_quiet();
    do @(negedge clk);
    while (pending_requests.size() != 0 || s_tvalid || awaited_results.size() != 0);
    repeat (6) @(posedge clk);
  endtask

  // The capacity register is only written while the block is quiet, so the shadow
  // copy can change at the same time.
  task automatic write_capacity(input logic [ctwq_pkg::CAP_CFG_W-1:0] value);
    @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    capacity_setting = value;
    @(posedge clk);
    cfg_wen <= 1'b0;
  endtask

  // A run of random requests. reg_pct sets how many are registrations, which decides
  // whether the tables fill up or drain; the rest are mostly searches and deletes
  // with a few of the reserved kind.
  task automatic random_requests(input int count, input int reg_pct);
    int          n;
    int          r;
    int          rest;
    logic [1:0]  kind;
    logic [31:0] ident;
    rest = 100 - reg_pct;
    for (n = 0; n < count; n++) begin
      r = $urandom_range(99);
      if (r < reg_pct) kind = ctwq_pkg::KIND_REGISTER;
      else if (r < reg_pct + rest * 45 / 100) kind = ctwq_pkg::KIND_SEARCH;
      else if (r < reg_pct + rest * 90 / 100) kind = ctwq_pkg::KIND_DELETE;
      else kind = KIND_RESERVED;
      ident = ($urandom_range(3) != 0) ? ident_pool[$urandom_range(15)] : $urandom;
      queue_request(kind, ident);
    end
  endtask

  initial begin
    int phase_cap[8];
    int phase_len[8];
    int phase_reg[8];
    int phase_idle[8];
    int p;
    phase_cap  = '{2, 5, 0, 128, 1, 255, 40, 3};
    phase_len  = '{40, 40, 40, 120, 40, 40, 40, 40};
    phase_reg  = '{80, 75, 65, 85, 70, 25, 50, 40};
    phase_idle = '{37, 37, 37, 0, 37, 37, 37, 37};
    ident_pool[0] = 32'h0000_0000;
    ident_pool[1] = 32'hFFFF_FFFF;
    for (p = 2; p < 16; p++) ident_pool[p] = $urandom;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset capacity: the extreme identifiers go into the main
    // table, then a hit, a miss, the reserved kind, a delete that compacts the table
    // and a delete miss with nothing waiting to be promoted.
    queue_request(ctwq_pkg::KIND_REGISTER, 32'h0000_0000);
    queue_request(ctwq_pkg::KIND_REGISTER, 32'hFFFF_FFFF);
    queue_request(ctwq_pkg::KIND_REGISTER, 32'h8000_0000);
    queue_request(ctwq_pkg::KIND_REGISTER, 32'h7FFF_FFFF);
    queue_request(ctwq_pkg::KIND_SEARCH, 32'h7FFF_FFFF);
    queue_request(ctwq_pkg::KIND_SEARCH, 32'h1234_5678);
    queue_request(KIND_RESERVED, 32'hFFFF_FFFF);
    queue_request(ctwq_pkg::KIND_DELETE, 32'h8000_0000);
    queue_request(ctwq_pkg::KIND_DELETE, 32'h0000_0055);
    wait_for_quiet();

    // Capacity zero while three entries sit in the main table: nothing is evicted,
    // registrations go to the queue and a delete promotes nothing.
    write_capacity(8'd0);
    queue_request(ctwq_pkg::KIND_REGISTER, 32'hA5A5_A5A5);
    queue_request(ctwq_pkg::KIND_REGISTER, 32'h5A5A_5A5A);
    queue_request(ctwq_pkg::KIND_SEARCH, 32'h5A5A_5A5A);
    queue_request(ctwq_pkg::KIND_DELETE, 32'hFFFF_FFFF);
    wait_for_quiet();

    // A capacity above the table depth. A delete miss still promotes the oldest
    // queued entry, and a delete hit promotes the next one.
    write_capacity(8'd255);
    queue_request(ctwq_pkg::KIND_DELETE, 32'h0000_0001);
    queue_request(ctwq_pkg::KIND_DELETE, 32'h0000_0000);
    wait_for_quiet();

    // Random phases across several capacities. The low ones early on push the queue
    // to full, the one at full depth runs without any idling on either side, and the
    // later ones drop the capacity below the fill and then drain the tables.
    for (p = 0; p < 8; p++) begin
      write_capacity(ctwq_pkg::CAP_CFG_W'(phase_cap[p]));
      idle_pct = phase_idle[p];
      random_requests(phase_len[p], phase_reg[p]);
      wait_for_quiet();
    end

    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog: a correct run needs a small fraction of this time.
  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+sv
sv/ctwq_pkg.sv
sv/ctwq_cell.sv
sv/ctwq_scan.sv
sv/capacity_table_with_waiting_queue.sv
bench/capacity_table_with_waiting_queue_tb.sv
